@@ hdl/u8u16_pkg.sv @@
`default_nettype none

package u8u16_pkg;

    localparam int U8U16_FIFO_DEPTH = 4;

    localparam logic [20:0] PLANE1_START        = 21'h010000;
    localparam logic [20:0] MAX_CODE            = 21'h10FFFF;
    localparam logic [20:0] SURR_FIRST          = 21'h00D800;
    localparam logic [20:0] SURR_LAST           = 21'h00DFFF;
    localparam logic [20:0] THREE_BYTE_MIN_BITS = 21'h00F800;
    localparam logic [20:0] FOUR_BYTE_MIN_BITS  = 21'h1F0000;
    localparam logic [10:0] TWO_BYTE_MIN_BITS   = 11'h780;
    localparam logic [15:0] SURR_HIGH_BASE      = 16'hD800;
    localparam logic [15:0] SURR_LOW_BASE       = 16'hDC00;
    localparam logic [9:0]  TEN_BIT_MASK        = 10'h3FF;

    // One result as it leaves the block, less the last-unit flag.
    typedef struct packed {
        logic [15:0] unit;
        logic        err;
        logic        str_end;
    } res_t;

    // Everything one input byte produces: one result, or two when pair is set.
    typedef struct packed {
        res_t r0;
        res_t r1;
        logic pair;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

`default_nettype wire

@@ hdl/u8u16_front.sv @@
`default_nettype none

module u8u16_front
    import u8u16_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] in_byte,
    output entry_t          wr_entry,
    output logic            wr_en
);

    typedef struct packed {
        logic        has;
        res_t        res;
        logic [1:0]  pend;
        logic [1:0]  seq;
        logic [20:0] part;
    } lead_t;

    logic [1:0]  pend_reg, pend_next;
    logic [1:0]  seq_reg, seq_next;
    logic [20:0] part_reg, part_next;

    function automatic lead_t decode_lead(input logic [7:0] b);
        lead_t l;
        logic [10:0] c2;
        l = '0;
        c2 = {b[4:0], 6'b0};
        if (!b[7]) begin
            l.has = 1'b1;
            l.res.unit = {8'b0, b};
            l.res.str_end = (b == 8'h00);
        end else if (b[7:5] == 3'b110) begin
            if ((c2 & TWO_BYTE_MIN_BITS) == '0) begin
                l.has = 1'b1;
                l.res.err = 1'b1;
            end else begin
                l.part = {10'b0, c2};
                l.pend = 2'd1;
                l.seq = 2'd1;
            end
        end else if (b[7:4] == 4'b1110) begin
            l.part = {5'b0, b[3:0], 12'b0};
            l.pend = 2'd2;
            l.seq = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
            l.part = {b[2:0], 18'b0};
            l.pend = 2'd3;
            l.seq = 2'd3;
        end else begin
            l.has = 1'b1;
            l.res.err = 1'b1;
        end
        return l;
    endfunction

    always_comb
    begin
        lead_t       l;
        logic [20:0] sh;
        logic [20:0] c;
        logic [20:0] d;
        logic        first;
        logic [1:0]  left;

        l = decode_lead(in_byte);
        case (pend_reg)
            2'd1:    sh = {15'b0, in_byte[5:0]};
            2'd2:    sh = {9'b0, in_byte[5:0], 6'b0};
            2'd3:    sh = {3'b0, in_byte[5:0], 12'b0};
            default: sh = '0;
        endcase
        c = part_reg | sh;
        d = c - PLANE1_START;
        first = (pend_reg == seq_reg);
        left = pend_reg - 2'd1;

        pend_next = pend_reg;
        seq_next = seq_reg;
        part_next = part_reg;
        wr_entry = '0;
        wr_en = 1'b0;

        if (accept) begin
            if (pend_reg != 2'd0 && in_byte[7:6] == 2'b10) begin
                pend_next = '0;
                seq_next = '0;
                part_next = '0;
                if (first && ((seq_reg == 2'd2 && (c & THREE_BYTE_MIN_BITS) == '0)
                        || (seq_reg == 2'd3 && (c & FOUR_BYTE_MIN_BITS) == '0))) begin
                    wr_en = 1'b1;
                    wr_entry.r0.err = 1'b1;
                end else if (left != 2'd0) begin
                    // hold the sequence, more continuation bytes to come
                    pend_next = left;
                    seq_next = seq_reg;
                    part_next = c;
                end else if ((c >= SURR_FIRST && c <= SURR_LAST) || c > MAX_CODE) begin
                    wr_en = 1'b1;
                    wr_entry.r0.err = 1'b1;
                end else if (c >= PLANE1_START) begin
                    wr_en = 1'b1;
                    wr_entry.pair = 1'b1;
                    wr_entry.r0.unit = SURR_HIGH_BASE | {6'b0, d[19:10]};
                    wr_entry.r1.unit = SURR_LOW_BASE | {6'b0, d[9:0] & TEN_BIT_MASK};
                end else begin
                    wr_en = 1'b1;
                    wr_entry.r0.unit = c[15:0];
                    wr_entry.r0.str_end = (c == '0);
                end
            end else if (pend_reg != 2'd0) begin
                // missing continuation: drop the sequence, then decode as lead
                wr_en = 1'b1;
                wr_entry.r0.err = 1'b1;
                wr_entry.pair = l.has;
                wr_entry.r1 = l.res;
                pend_next = l.pend;
                seq_next = l.seq;
                part_next = l.part;
            end else begin
                wr_en = l.has;
                wr_entry.r0 = l.res;
                pend_next = l.pend;
                seq_next = l.seq;
                part_next = l.part;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pend_reg <= '0;
            seq_reg <= '0;
            part_reg <= '0;
        end else begin
            pend_reg <= pend_next;
            seq_reg <= seq_next;
            part_reg <= part_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/u8u16_fifo.sv @@
`default_nettype none

module u8u16_fifo
    import u8u16_pkg::*;
#(
    parameter int DEPTH = U8U16_FIFO_DEPTH
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       wr_en,
    input  wire entry_t                     wr_entry,
    input  wire logic                       rd_en,
    output entry_t                          rd_entry,
    output fifo_stat_t                      stat,
    output logic [$clog2(DEPTH + 1) - 1:0]  count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem_reg [DEPTH];
    logic [PTR_W - 1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W - 1:0] cnt_reg;
    logic               do_wr, do_rd;

    assign do_wr = wr_en && !stat.full;
    assign do_rd = rd_en && !stat.empty;
    assign stat.full = (cnt_reg == CNT_W'(DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign rd_entry = mem_reg[rd_ptr_reg];
    assign count = cnt_reg;

    function automatic logic [PTR_W - 1:0] bump(input logic [PTR_W - 1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_rd) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            case ({do_wr, do_rd})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hdl/u8u16_back.sv @@
`default_nettype none

module u8u16_back
    import u8u16_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire entry_t      rd_entry,
    input  wire fifo_stat_t  stat,
    output logic             rd_en,
    input  wire logic        pop,
    output logic             empty,
    output logic [15:0]      code_unit,
    output logic             is_error,
    output logic             last_unit,
    output logic             string_end
);

    logic out_valid_reg;
    res_t out_res_reg;
    logic out_last_reg;
    logic hold_valid_reg;
    res_t hold_res_reg;
    logic load;

    // advance whenever the output slot is free or being taken
    assign load = !out_valid_reg || pop;
    assign rd_en = load && !hold_valid_reg && !stat.empty;

    assign empty = !out_valid_reg;
    assign code_unit = out_res_reg.unit;
    assign is_error = out_res_reg.err;
    assign string_end = out_res_reg.str_end;
    assign last_unit = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (load) begin
            if (hold_valid_reg) begin
                out_res_reg <= hold_res_reg;
                out_last_reg <= 1'b1;
            end else begin
                out_res_reg <= rd_entry.r0;
                out_last_reg <= !rd_entry.pair;
                hold_res_reg <= rd_entry.r1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else if (load) begin
            if (hold_valid_reg) begin
                out_valid_reg <= 1'b1;
                hold_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= !stat.empty;
                hold_valid_reg <= !stat.empty && rd_entry.pair;
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/utf8_to_utf16_converter_top.sv @@
// A byte's first result enters the queue as the byte transfers, then the output register.
// Throughput: one byte per cycle while full is low; a surrogate-pair byte needs two result pops.
// The queue between decoder and output stage (FIFO_DEPTH entries) sets how long pops may stall
// before full rises.
// Reset (rst_n low, asynchronous): decoder waits for a lead byte, queue and output are empty.
`default_nettype none

module utf8_to_utf16_converter_top
    import u8u16_pkg::*;
#(
    parameter int FIFO_DEPTH = U8U16_FIFO_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  in_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [15:0]      code_unit,
    output logic             is_error,
    output logic             last_unit,
    output logic             string_end
);

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    entry_t             wr_entry;
    entry_t             rd_entry;
    logic               wr_en;
    logic               rd_en;
    fifo_stat_t         stat;
    logic [CNT_W - 1:0] fifo_count;
    logic               accept;

    // A byte transfers whenever the queue has room, whether or not it yields a result.
    assign full = stat.full;
    assign accept = push && !stat.full;

    // Front: hold the partial code point, classify each byte and write its results as one entry.
    u8u16_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_byte  (in_byte),
        .wr_entry (wr_entry),
        .wr_en    (wr_en)
    );

    // Queue: decouple decoding from result delivery so either side may stall alone.
    u8u16_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_entry (wr_entry),
        .rd_en    (rd_en),
        .rd_entry (rd_entry),
        .stat     (stat),
        .count    (fifo_count)
    );

    // Back: present results one per transfer, holding the low surrogate of a pair aside.
    u8u16_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_entry   (rd_entry),
        .stat       (stat),
        .rd_en      (rd_en),
        .pop        (pop),
        .empty      (empty),
        .code_unit  (code_unit),
        .is_error   (is_error),
        .last_unit  (last_unit),
        .string_end (string_end)
    );

`ifndef ASSERT_OFF
    // The queue occupancy never exceeds its depth, and full tracks it exactly.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fifo_count <= CNT_W'(FIFO_DEPTH)) && (stat.full == (fifo_count == CNT_W'(FIFO_DEPTH))))
        else $error("queue occupancy out of step with full");

    // An error result carries unit zero and no string end.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && is_error) |-> (code_unit == 16'h0000 && !string_end))
        else $error("error result with non-zero payload");

    // A string end is always a final, non-error unit of value zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && string_end) |-> (code_unit == 16'h0000 && last_unit && !is_error))
        else $error("malformed string end result");

    // A high surrogate is never the last result of its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && code_unit[15:10] == 6'b110110) |-> !last_unit)
        else $error("high surrogate marked as last unit");
`endif

endmodule

`default_nettype wire

@@ sim/utf16_result_checker.sv @@
`timescale 1ns / 100ps

module utf16_result_checker
    import u8u16_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire logic        full,
    input  wire logic [7:0]  in_byte,
    input  wire logic        empty,
    input  wire logic        pop,
    input  wire logic [15:0] code_unit,
    input  wire logic        is_error,
    input  wire logic        last_unit,
    input  wire logic        string_end,
    output int               mismatches,
    output int               outstanding,
    output int               results_seen,
    output int               error_results,
    output int               end_results,
    output int               surrogate_units
);

    typedef struct packed {
        logic [15:0] unit;
        logic        err;
        logic        last;
        logic        eos;
    } utf16_result_t;

    utf16_result_t expected_units[$];

    // Decoder state as the transcoder should hold it
    logic [1:0]  conts_left;
    logic [1:0]  seq_conts;
    logic [20:0] code_acc;

    // Results of the byte being decoded, at most two
    logic [15:0] step_unit [0:1];
    logic        step_err  [0:1];
    logic        step_eos  [0:1];
    int          step_n;

    assign outstanding = expected_units.size();

    task automatic drop_sequence();
        conts_left = '0;
        seq_conts  = '0;
        code_acc   = '0;
    endtask

    task automatic note_result(input logic [15:0] unit, input logic err, input logic eos);
        step_unit[step_n] = unit;
        step_err[step_n]  = err;
        step_eos[step_n]  = eos;
        step_n++;
    endtask

    task automatic start_sequence(input logic [7:0] b);
        logic [10:0] lead_bits;
        lead_bits = {b[4:0], 6'b0};
        if (!b[7])
            note_result({8'h00, b}, 1'b0, b == 8'h00);
        else if (b[7:5] == 3'b110)
        begin
            // two-byte leads carrying fewer than eight payload bits are overlong
            if ((lead_bits & TWO_BYTE_MIN_BITS) == '0)
                note_result(16'h0000, 1'b1, 1'b0);
            else
            begin
                code_acc   = {10'b0, b[4:0], 6'b0};
                conts_left = 2'd1;
                seq_conts  = 2'd1;
            end
        end
        else if (b[7:4] == 4'b1110)
        begin
            code_acc   = {5'b0, b[3:0], 12'b0};
            conts_left = 2'd2;
            seq_conts  = 2'd2;
        end
        else if (b[7:3] == 5'b11110)
        begin
            code_acc   = {b[2:0], 18'b0};
            conts_left = 2'd3;
            seq_conts  = 2'd3;
        end
        else
            note_result(16'h0000, 1'b1, 1'b0);
    endtask

    task automatic extend_sequence(input logic [7:0] b);
        logic [20:0] c;
        logic [20:0] d;
        logic        first;
        int          shift;
        shift = 6 * (int'(conts_left) - 1);
        c     = code_acc | (21'(b[5:0]) << shift);
        first = (conts_left == seq_conts);
        if ((first && seq_conts == 2'd2 && (c & THREE_BYTE_MIN_BITS) == '0)
            || (first && seq_conts == 2'd3 && (c & FOUR_BYTE_MIN_BITS) == '0))
        begin
            drop_sequence();
            note_result(16'h0000, 1'b1, 1'b0);
        end
        else
        begin
            code_acc   = c;
            conts_left = conts_left - 2'd1;
            if (conts_left == '0)
            begin
                drop_sequence();
                if ((c >= SURR_FIRST && c <= SURR_LAST) || c > MAX_CODE)
                    note_result(16'h0000, 1'b1, 1'b0);
                else if (c >= PLANE1_START)
                begin
                    d = c - PLANE1_START;
                    note_result(SURR_HIGH_BASE + 16'(d[19:10]), 1'b0, 1'b0);
                    note_result(SURR_LOW_BASE + 16'(d[9:0]), 1'b0, 1'b0);
                end
                else
                    note_result(c[15:0], 1'b0, c == '0);
            end
        end
    endtask

    task automatic decode_byte(input logic [7:0] b);
        step_n = 0;
        if (conts_left != '0)
        begin
            if (b[7:6] == 2'b10)
                extend_sequence(b);
            else
            begin
                // sequence cut short: error first, then take the byte as a lead
                drop_sequence();
                note_result(16'h0000, 1'b1, 1'b0);
                start_sequence(b);
            end
        end
        else
            start_sequence(b);
        for (int i = 0; i < step_n; i++)
            expected_units.push_back(utf16_result_t'{step_unit[i], step_err[i],
                                                     i == step_n - 1, step_eos[i]});
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result();
        utf16_result_t want;
        results_seen++;
        if (expected_units.size() == 0)
        begin
            $error("code_unit %h arrived with no result expected", code_unit);
            mismatches++;
        end
        else
        begin
            want = expected_units.pop_front();
            compare_field("code_unit", want.unit, code_unit);
            compare_field("is_error", want.err, is_error);
            compare_field("last_unit", want.last, last_unit);
            compare_field("string_end", want.eos, string_end);
            if (want.err)
                error_results++;
            if (want.eos)
                end_results++;
            if (!want.err && want.unit >= 16'hD800 && want.unit <= 16'hDFFF)
                surrogate_units++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_sequence();
            expected_units.delete();
            mismatches      <= 0;
            results_seen    <= 0;
            error_results   <= 0;
            end_results     <= 0;
            surrogate_units <= 0;
        end
        else
        begin
            if (push && !full)
                decode_byte(in_byte);
            if (pop && !empty)
                check_result();
        end
    end

endmodule

@@ sim/tb_utf8_to_utf16_converter_top.sv @@
`timescale 1ns / 100ps

module tb_utf8_to_utf16_converter_top;

    // Cycles without any transfer on either side before the run is abandoned
    localparam int STALL_LIMIT = 2000;
    // Random bytes to drive after the directed opening
    localparam int RANDOM_BYTES = 950;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  in_byte;
    logic        empty;
    logic        pop;
    logic [15:0] code_unit;
    logic        is_error;
    logic        last_unit;
    logic        string_end;

    int mismatches;
    int outstanding;
    int results_seen;
    int error_results;
    int end_results;
    int surrogate_units;

    int bytes_sent;
    int quiet_cycles;
    // Set for whole stretches of the run: both sides then offer transfers back to back
    logic no_idle;

    utf8_to_utf16_converter_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .in_byte    (in_byte),
        .empty      (empty),
        .pop        (pop),
        .code_unit  (code_unit),
        .is_error   (is_error),
        .last_unit  (last_unit),
        .string_end (string_end)
    );

    utf16_result_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .in_byte         (in_byte),
        .empty           (empty),
        .pop             (pop),
        .code_unit       (code_unit),
        .is_error        (is_error),
        .last_unit       (last_unit),
        .string_end      (string_end),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_seen    (results_seen),
        .error_results   (error_results),
        .end_results     (end_results),
        .surrogate_units (surrogate_units)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Offer one byte and hold it until the block takes it. Called at a falling
    // edge and returns at the falling edge after the transfer, so a back-to-back
    // byte assigns push only once in that time step.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        // every fourth stretch of 120 bytes runs with no idling at all
        no_idle = ((bytes_sent / 120) % 4) == 3;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push    <= 1'b1;
        in_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    // One random chunk of stream: half the time a lead byte followed by its full
    // set of continuation bytes with random payload, so that complete code points,
    // overlong forms, surrogates and out-of-range values all come up; the rest is
    // plain ASCII, truncated sequences, stray continuation bytes and plain noise.
    task automatic send_random_chunk();
        int         kind;
        int         conts;
        int         keep;
        logic [7:0] lead;
        kind  = $urandom_range(0, 9);
        conts = 0;
        case (kind)
            0, 1: send_byte(8'($urandom_range(0, 127)));
            2:    begin lead = 8'hC0 | 8'($urandom_range(2, 31)); conts = 1; end
            3, 4: begin lead = 8'hE0 | 8'($urandom_range(0, 15)); conts = 2; end
            5, 6:
            begin
                // leads F5-F7 only now and then: they always overshoot the code range
                lead  = 8'hF0 | 8'(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7)
                                                               : $urandom_range(0, 4));
                conts = 3;
            end
            7:
            begin
                // truncated: the next chunk's first byte interrupts it unless it is a continuation byte
                conts = $urandom_range(1, 3);
                case (conts)
                    1:       lead = 8'hC0 | 8'($urandom_range(0, 31));
                    2:       lead = 8'hE0 | 8'($urandom_range(0, 15));
                    default: lead = 8'hF0 | 8'($urandom_range(0, 7));
                endcase
            end
            8:       send_byte(8'($urandom_range(0, 255)));
            default: send_byte(8'h80 | 8'($urandom_range(0, 63)));
        endcase
        if (conts > 0)
        begin
            keep = (kind == 7) ? $urandom_range(0, conts - 1) : conts;
            send_byte(lead);
            repeat (keep)
                send_byte(8'h80 | 8'($urandom_range(0, 63)));
        end
    endtask

    // Result side: draw a stall for each result, then hold pop until one transfers
    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            int stall;
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // Watchdog: abandon the run once nothing has transferred for too long
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] directed_bytes[];
        directed_bytes = '{
            8'h00,                      // zero terminator
            8'h80, 8'hC1, 8'hF8, 8'hFF, // stray continuation, overlong lead, invalid leads
            8'hC2, 8'h80,               // smallest two-byte code point
            8'hE0, 8'h80,               // overlong three-byte form, caught on first continuation
            8'hED, 8'hA0, 8'h80,        // surrogate code point
            8'hF4, 8'h8F, 8'hBF, 8'hBF, // highest code point, a surrogate pair
            8'hF0, 8'h80,               // overlong four-byte form
            8'hF4, 8'h90, 8'h80, 8'h80, // just past the code range
            8'hC3, 8'h41,               // missing continuation, then a plain ASCII lead
            8'h7F
        };
        rst_n        = 1'b0;
        push         = 1'b0;
        in_byte      = 8'h00;
        no_idle      = 1'b0;
        bytes_sent   = 0;
        quiet_cycles = 0;

        // Hold reset, then release it away from the rising edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);
        while (bytes_sent < directed_bytes.size() + RANDOM_BYTES)
            send_random_chunk();
        push <= 1'b0;

        // Drain: wait for every expected result, then give stray extras a chance
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Transcoded %0d bytes of ASCII, multi-byte, overlong, surrogate and broken input;",
                 bytes_sent);
        $display("%0d units checked: %0d errors, %0d surrogate halves, %0d string ends",
                 results_seen, error_results, surrogate_units, end_results);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/u8u16_pkg.sv
hdl/u8u16_front.sv
hdl/u8u16_fifo.sv
hdl/u8u16_back.sv
hdl/utf8_to_utf16_converter_top.sv
sim/utf16_result_checker.sv
sim/tb_utf8_to_utf16_converter_top.sv
